### sv/fpa_pkg.sv
package fpa_pkg;

   localparam int FRACTION_BITS = 8;
   localparam int QUOT_W = 32 + FRACTION_BITS;

   typedef enum logic [3:0] {
      ACT_ADD      = 4'd0,
      ACT_SUB      = 4'd1,
      ACT_MUL      = 4'd2,
      ACT_DIV      = 4'd3,
      ACT_EQ       = 4'd4,
      ACT_NE       = 4'd5,
      ACT_GT       = 4'd6,
      ACT_LT       = 4'd7,
      ACT_GE       = 4'd8,
      ACT_LE       = 4'd9,
      ACT_MIN      = 4'd10,
      ACT_MAX      = 4'd11,
      ACT_INC      = 4'd12,
      ACT_DEC      = 4'd13,
      ACT_TO_INT   = 4'd14,
      ACT_FROM_INT = 4'd15
   } action_type;

   typedef struct packed {
      action_type         action;
      logic               neg;
      logic [31:0]        den;
      logic [31:0]        rem;
      logic [QUOT_W-1:0]  num;
      logic [QUOT_W-1:0]  quot;
      logic [31:0]        res;
      logic               cmp;
      logic               ovf;
   } stage_type;

   // Saturates a magnitude with a sign; the top bit of the result is overflow.
   function automatic logic [32:0] sat_mag(input logic [63:0] mag, input logic neg);
      logic [32:0] r;
      if (!neg) begin
         if (mag > 64'h0000_0000_7FFF_FFFF) begin
            r = {1'b1, 32'h7FFF_FFFF};
         end else begin
            r = {1'b0, mag[31:0]};
         end
      end else begin
         if (mag > 64'h0000_0000_8000_0000) begin
            r = {1'b1, 32'h8000_0000};
         end else begin
            r = {1'b0, (~mag[31:0]) + 32'd1};
         end
      end
      return r;
   endfunction

   // Saturates a 33-bit signed sum to 32 bits; the top bit of the result is overflow.
   function automatic logic [32:0] sat_sum(input logic [32:0] s);
      logic [32:0] r;
      if (s[32] != s[31]) begin
         r = {1'b1, s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF};
      end else begin
         r = {1'b0, s[31:0]};
      end
      return r;
   endfunction

endpackage

### sv/fixed_point_alu_unit.sv
// Channel  Direction  Accepted when            Payload
// req      in         req_tvalid & req_tready  tuser: action; tdata: operand_a, operand_b
// rsp      out        rsp_tvalid & rsp_tready  tdata: result_value and three flags
// Every item passes through the full pipeline from acceptance to the result; its depth is set by the
// divider, which resolves one quotient bit per pipeline stage. One item enters per cycle unless rsp stalls.
// Each stage holds while the stage after it is full and stalled, so bubbles close up.
// Synchronous reset clears all valid bits; payload registers are not reset.
module fixed_point_alu_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [3:0]  req_tuser,   // action
   input  logic [63:0] req_tdata,   // operand_a [31:0], operand_b [63:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // result_value, compare_true, overflow,
                                    // divide_by_zero, zero fill [39:35]
);
   import fpa_pkg::*;

   localparam int NS = QUOT_W + 1;

   logic               in_v_ff;
   action_type         in_act_ff;
   logic signed [31:0] in_a_ff;
   logic signed [31:0] in_b_ff;
   logic               in_en;

   stage_type          p0_in;
   stage_type          p_ff [NS];
   stage_type          p_in [NS];
   logic               v_ff [NS];
   logic               en   [NS];
   logic signed [63:0] prod_ff;
   logic signed [63:0] prod_in;

   logic               rsp_v_ff;
   logic [31:0]        rsp_res_ff, rsp_res_in;
   logic               rsp_cmp_ff, rsp_cmp_in;
   logic               rsp_ovf_ff, rsp_ovf_in;
   logic               rsp_dz_ff, rsp_dz_in;
   logic               out_en;

   always_comb begin
      out_en = !rsp_v_ff || rsp_tready;
      en[NS-1] = !v_ff[NS-1] || out_en;
      for (int k = NS - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
      in_en = !in_v_ff || en[0];
   end

   assign req_tready = in_en;

   always_comb begin
      logic [32:0] s;
      logic [31:0] ma;
      logic [31:0] mb;
      logic        lt;
      stage_type   st;
      st = '0;
      st.action = in_act_ff;
      ma = in_a_ff[31] ? (~in_a_ff) + 32'd1 : in_a_ff;
      mb = in_b_ff[31] ? (~in_b_ff) + 32'd1 : in_b_ff;
      st.neg = in_a_ff[31] ^ in_b_ff[31];
      st.den = mb;
      st.num = {ma, {FRACTION_BITS{1'b0}}};
      lt = in_a_ff < in_b_ff;
      s = '0;
      case (in_act_ff)
         ACT_ADD: begin
            s = {in_a_ff[31], in_a_ff} + {in_b_ff[31], in_b_ff};
            {st.ovf, st.res} = sat_sum(s);
         end
         ACT_SUB: begin
            s = {in_a_ff[31], in_a_ff} - {in_b_ff[31], in_b_ff};
            {st.ovf, st.res} = sat_sum(s);
         end
         ACT_INC: begin
            s = {in_a_ff[31], in_a_ff} + 33'd1;
            {st.ovf, st.res} = sat_sum(s);
         end
         ACT_DEC: begin
            s = {in_a_ff[31], in_a_ff} - 33'd1;
            {st.ovf, st.res} = sat_sum(s);
         end
         ACT_EQ:  st.cmp = in_a_ff == in_b_ff;
         ACT_NE:  st.cmp = in_a_ff != in_b_ff;
         ACT_GT:  st.cmp = in_a_ff > in_b_ff;
         ACT_LT:  st.cmp = lt;
         ACT_GE:  st.cmp = !lt;
         ACT_LE:  st.cmp = in_a_ff <= in_b_ff;
         ACT_MIN: st.res = lt ? in_a_ff : in_b_ff;
         ACT_MAX: st.res = lt ? in_b_ff : in_a_ff;
         ACT_TO_INT: st.res = in_a_ff >>> FRACTION_BITS;
         ACT_FROM_INT: begin
            if ((in_a_ff >>> (31 - FRACTION_BITS)) != 32'sd0 &&
                (in_a_ff >>> (31 - FRACTION_BITS)) != -32'sd1) begin
               st.ovf = 1'b1;
               st.res = in_a_ff[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end else begin
               st.res = in_a_ff <<< FRACTION_BITS;
            end
         end
         default: st.res = '0;
      endcase
      p0_in = st;
      prod_in = in_a_ff * in_b_ff;
   end

   always_comb begin
      logic [32:0] rem2;
      logic [63:0] pm;
      logic [63:0] pq;
      p_in[0] = p0_in;
      for (int k = 1; k < NS; k++) begin
         p_in[k] = p_ff[k-1];
         rem2 = {p_ff[k-1].rem, p_ff[k-1].num[QUOT_W-1]};
         p_in[k].num = {p_ff[k-1].num[QUOT_W-2:0], 1'b0};
         if (rem2 >= {1'b0, p_ff[k-1].den}) begin
            p_in[k].rem = 32'(rem2 - {1'b0, p_ff[k-1].den});
            p_in[k].quot = {p_ff[k-1].quot[QUOT_W-2:0], 1'b1};
         end else begin
            p_in[k].rem = rem2[31:0];
            p_in[k].quot = {p_ff[k-1].quot[QUOT_W-2:0], 1'b0};
         end
      end
      pm = prod_ff[63] ? (~prod_ff) + 64'd1 : prod_ff;
      pq = (pm + (64'd1 << (FRACTION_BITS - 1))) >> FRACTION_BITS;
      if (p_ff[0].action == ACT_MUL) begin
         {p_in[1].ovf, p_in[1].res} = sat_mag(pq, prod_ff[63]);
      end
   end

   always_comb begin
      logic [QUOT_W:0] q;
      stage_type       lst;
      lst = p_ff[NS-1];
      rsp_res_in = lst.res;
      rsp_cmp_in = lst.cmp;
      rsp_ovf_in = lst.ovf;
      rsp_dz_in  = 1'b0;
      q = {1'b0, lst.quot} + ({lst.rem, 1'b0} >= {1'b0, lst.den} ? 1'b1 : 1'b0);
      if (lst.action == ACT_DIV) begin
         if (lst.den == 32'd0) begin
            rsp_res_in = '0;
            rsp_ovf_in = 1'b0;
            rsp_dz_in  = 1'b1;
         end else begin
            {rsp_ovf_in, rsp_res_in} = sat_mag(64'(q), lst.neg);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
         for (int k = 0; k < NS; k++) begin
            v_ff[k] <= 1'b0;
         end
      end else begin
         if (in_en) begin
            in_v_ff <= req_tvalid;
         end
         if (en[0]) begin
            v_ff[0] <= in_v_ff;
         end
         for (int k = 1; k < NS; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
         if (out_en) begin
            rsp_v_ff <= v_ff[NS-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_en) begin
         in_act_ff <= action_type'(req_tuser);
         in_a_ff   <= req_tdata[31:0];
         in_b_ff   <= req_tdata[63:32];
      end
      if (en[0]) begin
         p_ff[0] <= p_in[0];
         prod_ff <= prod_in;
      end
      for (int k = 1; k < NS; k++) begin
         if (en[k]) begin
            p_ff[k] <= p_in[k];
         end
      end
      if (out_en) begin
         rsp_res_ff <= rsp_res_in;
         rsp_cmp_ff <= rsp_cmp_in;
         rsp_ovf_ff <= rsp_ovf_in;
         rsp_dz_ff  <= rsp_dz_in;
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = {5'd0, rsp_dz_ff, rsp_ovf_ff, rsp_cmp_ff, rsp_res_ff};

endmodule

### sim/tb_fixed_point_alu_unit.sv
`timescale 1ns / 1ps

module tb_fixed_point_alu_unit;
   import fpa_pkg::*;

   localparam int LATENCY = 32 + FRACTION_BITS + 3;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic        divide_by_zero;
      logic        overflow;
      logic        compare_true;
      logic [31:0] result_value;
   } alu_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [3:0]  req_tuser = '0;
   logic [63:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;

   alu_result_type expected_results[$];
   int          mismatch_count = 0;
   int          items_sent = 0;
   int          results_seen = 0;
   int          idle_cycles = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;

   fixed_point_alu_unit DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tuser(req_tuser), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #4 clock = ~clock;

   function automatic logic [31:0] saturate(input logic signed [65:0] v, inout logic ovf);
      if (v > 66'sd2147483647) begin
         ovf = 1'b1;
         return 32'h7FFF_FFFF;
      end
      if (v < -66'sd2147483648) begin
         ovf = 1'b1;
         return 32'h8000_0000;
      end
      return v[31:0];
   endfunction

   function automatic alu_result_type compute_alu(input action_type act,
                                                  input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      alu_result_type r;
      logic signed [65:0] wa, wb, p, v;
      logic [65:0] mag, num, den, q, rem;
      logic ovf;
      r = '0;
      ovf = 1'b0;
      wa = a;
      wb = b;
      case (act)
         ACT_ADD: r.result_value = saturate(wa + wb, ovf);
         ACT_SUB: r.result_value = saturate(wa - wb, ovf);
         ACT_MUL: begin
            p = wa * wb;
            mag = p < 0 ? -p : p;
            q = (mag + (66'd1 << (FRACTION_BITS - 1))) >> FRACTION_BITS;
            v = p < 0 ? -$signed(q) : $signed(q);
            r.result_value = saturate(v, ovf);
         end
         ACT_DIV: begin
            if (b == 0) begin
               r.divide_by_zero = 1'b1;
            end else begin
               num = (wa < 0 ? -wa : wa) << FRACTION_BITS;
               den = wb < 0 ? -wb : wb;
               q = num / den;
               rem = num % den;
               if (rem >= den - rem) q = q + 1;
               v = ((wa < 0) != (wb < 0)) ? -$signed(q) : $signed(q);
               r.result_value = saturate(v, ovf);
            end
         end
         ACT_EQ: r.compare_true = (a == b);
         ACT_NE: r.compare_true = (a != b);
         ACT_GT: r.compare_true = (a > b);
         ACT_LT: r.compare_true = (a < b);
         ACT_GE: r.compare_true = (a >= b);
         ACT_LE: r.compare_true = (a <= b);
         ACT_MIN: r.result_value = (a < b) ? a : b;
         ACT_MAX: r.result_value = (a >= b) ? a : b;
         ACT_INC: r.result_value = saturate(wa + 1, ovf);
         ACT_DEC: r.result_value = saturate(wa - 1, ovf);
         ACT_TO_INT: r.result_value = a >>> FRACTION_BITS;
         default: r.result_value = saturate(wa <<< FRACTION_BITS, ovf);
      endcase
      r.overflow = ovf;
      return r;
   endfunction

   task automatic send_item(input action_type act, input logic [31:0] a, input logic [31:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {b, a};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_results.push_back(compute_alu(act, a, b));
      items_sent++;
   endtask

   function automatic logic [31:0] pick_operand();
      case ($urandom_range(7))
         0: return 32'h7FFF_FFFF - $urandom_range(2);
         1: return 32'h8000_0000 + $urandom_range(2);
         2: return $urandom_range(3) - 1;
         3: return $urandom_range(4095) - 2048;
         4: return ($urandom_range(511) - 256) << FRACTION_BITS;
         default: return $urandom;
      endcase
   endfunction

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      send_item(ACT_ADD, 32'h7FFF_FFFF, 32'd1);
      send_item(ACT_SUB, 32'h8000_0000, 32'd1);
      send_item(ACT_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_item(ACT_MUL, 32'h8000_0000, 32'h7FFF_FFFF);
      send_item(ACT_MUL, 32'h0000_0180, 32'hFFFF_FF80);
      send_item(ACT_MUL, 32'h0000_0001, 32'h0000_0080);
      send_item(ACT_DIV, 32'h0000_0100, 32'd0);
      send_item(ACT_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
      send_item(ACT_DIV, 32'h0000_0100, 32'h0000_0300);
      send_item(ACT_DIV, 32'hFFFF_FF00, 32'h0000_0200);
      send_item(ACT_EQ, 32'd5, 32'd5);
      send_item(ACT_NE, 32'd5, 32'd5);
      send_item(ACT_GT, 32'h7FFF_FFFF, 32'h8000_0000);
      send_item(ACT_LT, 32'h7FFF_FFFF, 32'h8000_0000);
      send_item(ACT_GE, 32'd3, 32'd3);
      send_item(ACT_LE, 32'hFFFF_FFFF, 32'd0);
      send_item(ACT_MIN, 32'd7, 32'd7);
      send_item(ACT_MAX, 32'h8000_0000, 32'h7FFF_FFFF);
      send_item(ACT_INC, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_item(ACT_DEC, 32'h8000_0000, 32'h0);
      send_item(ACT_TO_INT, 32'hFFFF_FF01, 32'h0);
      send_item(ACT_TO_INT, 32'h8000_0000, 32'h0);
      send_item(ACT_FROM_INT, 32'h0080_0000, 32'h0);
      send_item(ACT_FROM_INT, 32'hFF7F_FFFF, 32'h0);
   endtask

   task automatic test_random(input int count, input int s_pct, input int r_pct);
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      for (int i = 0; i < count; i++) begin
         send_item(action_type'($urandom_range(15)), pick_operand(), pick_operand());
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      alu_result_type got, want;
      if (!reset && (req_tvalid && req_tready || rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout after %0d cycles with no item moving.", idle_cycles);
         $display("== FAIL ==");
         $finish;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[34:0];
         results_seen++;
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("Unexpected result %h.", got);
         end else begin
            want = expected_results.pop_front();
            if (got.result_value !== want.result_value || got.compare_true !== want.compare_true
                || got.overflow !== want.overflow
                || got.divide_by_zero !== want.divide_by_zero) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("Mismatch: expected value %h cmp %b ovf %b dz %b, got %h %b %b %b.",
                           want.result_value, want.compare_true, want.overflow,
                           want.divide_by_zero, got.result_value, got.compare_true,
                           got.overflow, got.divide_by_zero);
               end
            end
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      drain_results();
      test_random(300, 10, 58);
      drain_results();
      test_random(300, 58, 10);
      test_random(300, 0, 0);
      drain_results();
      repeat (LATENCY + 10) @(posedge clock);
      $display("Sent %0d items over all sixteen operations, checked %0d results.",
               items_sent, results_seen);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
